>>> rtl/core/bdac_pkg.sv
package bdac_pkg;

    localparam int VALUE_W    = 32;
    localparam int OP_W       = 3;
    localparam int CHAR_W     = 7;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int NDIG_W     = $clog2(BCD_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 7'h2E;
    localparam logic [CHAR_W-1:0] CHAR_VOLT  = 7'h56;

    typedef enum logic [OP_W-1:0] {
        OP_UNSIGNED    = 3'd0,
        OP_SIGNED      = 3'd1,
        OP_HUNDREDTHS  = 3'd2,
        OP_THOUSANDTHS = 3'd3,
        OP_MILLIVOLTS  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT,
        ST_POINT,
        ST_UNIT
    } emit_state_t;

    typedef struct packed {
        logic       neg;
        logic       volts;
        logic [1:0] frac_dig;
    } emit_cfg_t;

endpackage

>>> rtl/core/bdac_dabble.sv
module bdac_dabble
    import bdac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] bin,
    output logic               busy,
    output logic               done,
    output logic [BCD_W-1:0]   bcd
);

    logic [VALUE_W-1:0]   bin_reg;
    logic [VALUE_W-1:0]   bin_next;
    logic [BCD_W-1:0]     bcd_reg;
    logic [BCD_W-1:0]     bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic [BIT_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;

    // Each digit of five or more is corrected by three before the next shift.
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BIT_CNT_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

>>> rtl/core/bdac_emit.sv
module bdac_emit
    import bdac_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  emit_cfg_t         cfg,
    input  logic [BCD_W-1:0]  bcd,
    output logic              busy,
    output logic              strobe,
    output logic [CHAR_W-1:0] text_char,
    output logic              last
);

    emit_state_t       state_reg;
    emit_state_t       state_next;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  bcd_next;
    logic [NDIG_W-1:0] ndig_reg;
    logic [NDIG_W-1:0] ndig_next;
    emit_cfg_t         cfg_reg;
    emit_cfg_t         cfg_next;
    logic [3:0]        top_digit;
    logic [NDIG_W-1:0] min_dig;
    logic [NDIG_W-1:0] frac_w;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign frac_w    = NDIG_W'(cfg_reg.frac_dig);
    assign min_dig   = frac_w + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        ndig_next  = ndig_reg;
        cfg_next   = cfg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    bcd_next   = bcd;
                    ndig_next  = NDIG_W'(BCD_DIGITS);
                    cfg_next   = cfg;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == 4'd0 && ndig_reg > min_dig)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else if (cfg_reg.neg)
                begin
                    state_next = ST_SIGN;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                ndig_next = ndig_reg - 1'b1;
                if (ndig_reg == NDIG_W'(1))
                begin
                    state_next = cfg_reg.volts ? ST_UNIT : ST_IDLE;
                end
                else if (frac_w != '0 && ndig_reg - 1'b1 == frac_w)
                begin
                    state_next = ST_POINT;
                end
                else
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_POINT:
            begin
                state_next = ST_DIGIT;
            end
            ST_UNIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        strobe    = 1'b0;
        text_char = CHAR_ZERO;
        last      = 1'b0;
        unique case (state_reg)
            ST_SIGN:
            begin
                strobe    = 1'b1;
                text_char = CHAR_MINUS;
            end
            ST_DIGIT:
            begin
                strobe    = 1'b1;
                text_char = CHAR_ZERO + {3'b000, top_digit};
                last      = (ndig_reg == NDIG_W'(1)) && !cfg_reg.volts;
            end
            ST_POINT:
            begin
                strobe    = 1'b1;
                text_char = CHAR_POINT;
            end
            ST_UNIT:
            begin
                strobe    = 1'b1;
                text_char = CHAR_VOLT;
                last      = 1'b1;
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        ndig_reg <= ndig_next;
        cfg_reg  <= cfg_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

>>> rtl/core/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter.
// An item is taken at a rising clock edge with start high and busy low. The
// item carries a mode in op and a 32-bit number in value. Modes 5 to 7 are
// accepted and dropped without producing any text, and busy stays low.
// The text comes out one character per beat on text_char, marked by strobe
// for one cycle each; last marks the final character of the item.
// The receiver cannot stall the block: every beat must be taken as it comes.
// The number is converted by a bit-serial shift-and-add-three register that
// handles one bit per cycle.
// Leading zero digits are then dropped one per cycle, and the characters
// follow one per cycle.
// Busy stays high from acceptance through the last character, so a new
// item is taken only after the last character of the previous one.
// Reset clears all control state; the block comes out of reset idle.
module binary_to_decimal_ascii
    import bdac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [OP_W-1:0]    op,
    input  logic [VALUE_W-1:0] value,
    output logic               busy,
    output logic               strobe,
    output logic [CHAR_W-1:0]  text_char,
    output logic               last
);

    logic               accept;
    logic               op_valid;
    logic [VALUE_W-1:0] mag;
    emit_cfg_t          cfg_in;
    emit_cfg_t          cfg_reg;
    emit_cfg_t          cfg_next;
    logic               dab_busy;
    logic               dab_done;
    logic [BCD_W-1:0]   dab_bcd;
    logic               emit_busy;

    assign accept = start && !busy;

    always_comb
    begin
        op_valid        = 1'b1;
        mag             = value;
        cfg_in.neg      = 1'b0;
        cfg_in.volts    = 1'b0;
        cfg_in.frac_dig = 2'd0;
        case (op)
            OP_UNSIGNED:
            begin
                mag = value;
            end
            OP_SIGNED:
            begin
                cfg_in.neg = value[VALUE_W-1];
                mag        = value[VALUE_W-1] ? (~value + 1'b1) : value;
            end
            OP_HUNDREDTHS:
            begin
                cfg_in.frac_dig = 2'd2;
            end
            OP_THOUSANDTHS:
            begin
                cfg_in.frac_dig = 2'd3;
            end
            OP_MILLIVOLTS:
            begin
                mag             = {{(VALUE_W-16){1'b0}}, value[15:0]};
                cfg_in.volts    = 1'b1;
                cfg_in.frac_dig = 2'd3;
            end
            default:
            begin
                op_valid = 1'b0;
            end
        endcase
    end

    assign cfg_next = (accept && op_valid) ? cfg_in : cfg_reg;

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    bdac_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && op_valid),
        .bin   (mag),
        .busy  (dab_busy),
        .done  (dab_done),
        .bcd   (dab_bcd)
    );

    bdac_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dab_done),
        .cfg       (cfg_reg),
        .bcd       (dab_bcd),
        .busy      (emit_busy),
        .strobe    (strobe),
        .text_char (text_char),
        .last      (last)
    );

    assign busy = dab_busy || dab_done || emit_busy;

    a_strobe_in_item: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("character beat outside an item");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("character beat right after the last one");

    a_valid_op_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (op == OP_UNSIGNED || op == OP_SIGNED ||
        op == OP_HUNDREDTHS || op == OP_THOUSANDTHS || op == OP_MILLIVOLTS)
        |=> busy)
        else $error("accepted item did not start conversion");

    a_digit_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && text_char == CHAR_MINUS |=>
        strobe && text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 7'd9)
        else $error("minus sign not followed by a digit");

endmodule

>>> bench/binary_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps

module binary_to_decimal_ascii_tb;
    import bdac_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int RANDOM_ITEMS = 175;
    localparam int QUIET_TAIL   = 30;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_beat_t;

    typedef struct {
        logic [OP_W-1:0]    mode;
        logic [VALUE_W-1:0] num;
        bit                 typed;
        string              text;
    } text_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [OP_W-1:0]    op = '0;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               strobe;
    logic [CHAR_W-1:0]  text_char;
    logic               last;

    char_beat_t expected_chars[$];
    int         mismatch_count = 0;

    text_row_t directed_rows [] = '{
        '{OP_UNSIGNED,    32'd0,          1'b1, "0"},
        '{OP_UNSIGNED,    32'hFFFF_FFFF,  1'b1, "4294967295"},
        '{OP_UNSIGNED,    32'd9,          1'b1, "9"},
        '{OP_UNSIGNED,    32'd10,         1'b1, "10"},
        '{OP_UNSIGNED,    32'd1234567,    1'b0, ""},
        '{OP_SIGNED,      32'd0,          1'b1, "0"},
        '{OP_SIGNED,      32'h7FFF_FFFF,  1'b1, "2147483647"},
        '{OP_SIGNED,      32'h8000_0000,  1'b1, "-2147483648"},
        '{OP_SIGNED,      32'hFFFF_FFFF,  1'b1, "-1"},
        '{OP_SIGNED,      32'hFFFF_CFC7,  1'b0, ""},
        '{OP_HUNDREDTHS,  32'd0,          1'b1, "0.00"},
        '{OP_HUNDREDTHS,  32'hFFFF_FFFF,  1'b1, "42949672.95"},
        '{OP_HUNDREDTHS,  32'd5,          1'b1, "0.05"},
        '{OP_HUNDREDTHS,  32'd100,        1'b0, ""},
        '{OP_THOUSANDTHS, 32'd0,          1'b1, "0.000"},
        '{OP_THOUSANDTHS, 32'hFFFF_FFFF,  1'b1, "4294967.295"},
        '{OP_THOUSANDTHS, 32'd7,          1'b1, "0.007"},
        '{OP_THOUSANDTHS, 32'd1000,       1'b0, ""},
        '{OP_MILLIVOLTS,  32'd0,          1'b1, "0.000V"},
        '{OP_MILLIVOLTS,  32'h0000_FFFF,  1'b1, "65.535V"},
        '{OP_MILLIVOLTS,  32'hFFFF_0000,  1'b1, "0.000V"},
        '{OP_MILLIVOLTS,  32'h1234_0BB8,  1'b0, ""},
        '{OP_SPARE5,      32'hFFFF_FFFF,  1'b1, ""},
        '{OP_SPARE6,      32'd0,          1'b1, ""},
        '{OP_SPARE7,      32'hAAAA_AAAA,  1'b1, ""}
    };

    binary_to_decimal_ascii u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .op        (op),
        .value     (value),
        .busy      (busy),
        .strobe    (strobe),
        .text_char (text_char),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic string decimal_text(input logic [OP_W-1:0] mode,
                                           input logic [VALUE_W-1:0] num);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] frac;
        logic [15:0]        mv;
        string              s;
        mag = -num;
        mv  = num[15:0];
        s   = "";
        case (mode)
            OP_UNSIGNED:    s = $sformatf("%0d", num);
            OP_SIGNED:      s = num[VALUE_W-1] ? {"-", $sformatf("%0d", mag)}
                                               : $sformatf("%0d", num);
            OP_HUNDREDTHS:
            begin
                frac = num % 100;
                s = $sformatf("%0d.%0d%0d", num / 100, frac / 10, frac % 10);
            end
            OP_THOUSANDTHS:
            begin
                frac = num % 1000;
                s = $sformatf("%0d.%0d%0d%0d", num / 1000, frac / 100,
                              (frac / 10) % 10, frac % 10);
            end
            OP_MILLIVOLTS:
            begin
                frac = mv % 1000;
                s = $sformatf("%0d.%0d%0d%0dV", mv / 1000, frac / 100,
                              (frac / 10) % 10, frac % 10);
            end
            default:        s = "";
        endcase
        return s;
    endfunction

    function automatic void queue_text(input string s);
        char_beat_t beat;
        byte        b;
        for (int i = 0; i < s.len(); i++)
        begin
            b = s[i];
            beat.ch = b[CHAR_W-1:0];
            beat.last = (i == s.len() - 1);
            expected_chars.push_back(beat);
        end
    endfunction

    function automatic int pick_gap(input bit quiet);
        if (quiet || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] pow;
        int                 k;
        pow = 1;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 999);
            2:
            begin
                k = $urandom_range(0, 9);
                for (int i = 0; i < k; i++)
                    pow = pow * 10;
                return pow + $urandom_range(0, 2) - 1;
            end
            3: return {1'b1, 31'($urandom_range(0, 32'h7FFF_FFFF))};
            4: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return ($urandom << 16) | $urandom_range(0, 16'hFFFF);
        endcase
    endfunction

    task automatic send_item(input logic [OP_W-1:0] mode, input logic [VALUE_W-1:0] num,
                             input string text, input int gap);
        start <= 1'b1;
        op    <= mode;
        value <= num;
        do
            @(posedge clk);
        while (busy);
        queue_text(text);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        char_beat_t want;
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("unexpected beat: text_char %h last %b", text_char, last);
                mismatch_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (text_char !== want.ch)
                begin
                    $error("text_char: expected %h, actual %h", want.ch, text_char);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %b, actual %b", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        int               counted;
        logic [OP_W-1:0]  mode;
        logic [VALUE_W-1:0] num;
        counted = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].num,
                      directed_rows[i].typed ? directed_rows[i].text
                                             : decimal_text(directed_rows[i].mode,
                                                            directed_rows[i].num),
                      pick_gap(1'b0));

        while (counted < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                mode = OP_W'($urandom_range(OP_SPARE5, OP_SPARE7));
            else
                mode = OP_W'($urandom_range(OP_UNSIGNED, OP_MILLIVOLTS));
            num = random_value();
            if (mode <= OP_MILLIVOLTS)
                counted++;
            if (counted % 60 == 30 && expected_chars.size() != 0)
            begin
                start <= 1'b0;
                while (expected_chars.size() != 0) @(posedge clk);
            end
            send_item(mode, num, decimal_text(mode, num),
                      pick_gap(counted > RANDOM_ITEMS - QUIET_TAIL));
        end
        start <= 1'b0;

        while (expected_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bdac_pkg.sv
rtl/core/bdac_dabble.sv
rtl/core/bdac_emit.sv
rtl/core/binary_to_decimal_ascii.sv
bench/binary_to_decimal_ascii_tb.sv
